### sv/glp_pkg.sv
// Shared types, constants and the glow falloff table for the glow line shader.
// No dependencies; used by every module of the block through scoped names.
package glp_pkg;

    // How the projection t is formed for one pixel, and the no-write case.
    typedef enum logic [1:0] {
        K_NONE,   // beam off: result is a no-write
        K_ZERO,   // t = 0 (dot <= 0, or a dot-length segment)
        K_FULL,   // t = 256 (dot >= len2)
        K_DIV     // t = dot * 256 / len2
    } t_kind;

    localparam int CFG_IDX_BITS = 3;
    localparam logic [CFG_IDX_BITS-1:0] REG_START_X = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_START_Y = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_END_X   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_END_Y   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_BRIGHT  = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_THICK   = 3'd5;

    localparam int          T_FRAC_BITS = 8;        // quotient bits of t
    localparam logic [8:0]  T_ONE       = 9'd256;   // t at the segment end
    localparam int          GLOW_SHIFT  = 14;
    localparam int          GLOW_LEN    = 178;
    localparam logic [7:0]  LEVEL_MAX   = 8'd255;
    localparam int          QUEUE_DEPTH = 4;

    localparam logic [7:0] GLOW_TABLE [0:GLOW_LEN-1] = '{
        8'd255, 8'd247, 8'd240, 8'd232, 8'd225, 8'd218, 8'd211, 8'd205,
        8'd199, 8'd192, 8'd187, 8'd181, 8'd175, 8'd170, 8'd165, 8'd160,
        8'd155, 8'd150, 8'd145, 8'd141, 8'd136, 8'd132, 8'd128, 8'd124,
        8'd120, 8'd117, 8'd113, 8'd110, 8'd106, 8'd103, 8'd100, 8'd97,
        8'd94,  8'd91,  8'd88,  8'd85,  8'd83,  8'd80,  8'd78,  8'd75,
        8'd73,  8'd71,  8'd69,  8'd67,  8'd64,  8'd62,  8'd61,  8'd59,
        8'd57,  8'd55,  8'd53,  8'd52,  8'd50,  8'd49,  8'd47,  8'd46,
        8'd44,  8'd43,  8'd42,  8'd40,  8'd39,  8'd38,  8'd37,  8'd36,
        8'd35,  8'd33,  8'd32,  8'd31,  8'd30,  8'd30,  8'd29,  8'd28,
        8'd27,  8'd26,  8'd25,  8'd24,  8'd24,  8'd23,  8'd22,  8'd22,
        8'd21,  8'd20,  8'd20,  8'd19,  8'd18,  8'd18,  8'd17,  8'd17,
        8'd16,  8'd16,  8'd15,  8'd15,  8'd14,  8'd14,  8'd14,  8'd13,
        8'd13,  8'd12,  8'd12,  8'd12,  8'd11,  8'd11,  8'd11,  8'd10,
        8'd10,  8'd10,  8'd9,   8'd9,   8'd9,   8'd8,   8'd8,   8'd8,
        8'd8,   8'd7,   8'd7,   8'd7,   8'd7,   8'd7,   8'd6,   8'd6,
        8'd6,   8'd6,   8'd6,   8'd5,   8'd5,   8'd5,   8'd5,   8'd5,
        8'd5,   8'd5,   8'd4,   8'd4,   8'd4,   8'd4,   8'd4,   8'd4,
        8'd4,   8'd4,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,   8'd3,
        8'd3,   8'd3,   8'd3,   8'd3,   8'd2,   8'd2,   8'd2,   8'd2,
        8'd2,   8'd2,   8'd2,   8'd2,   8'd2,   8'd2,   8'd2,   8'd2,
        8'd2,   8'd2,   8'd2,   8'd2,   8'd2,   8'd1,   8'd1,   8'd1,
        8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,
        8'd1,   8'd1
    };

    // Entries past the table end read as zero.
    function automatic logic [7:0] glow_entry(input logic [7:0] idx);
        if (int'(idx) < GLOW_LEN) begin
            return GLOW_TABLE[idx];
        end
        return 8'd0;
    endfunction

    // Bits of one front-to-back queue entry: ddx, ddy, dx, dy, dot, len2, kind, old.
    function automatic int item_bits(input int cb);
        return 4 * (cb + 1) + 2 * (2 * cb + 3) + 2 + 8;
    endfunction

endpackage

### sv/glow_line_pixel_shader.sv
// Glow line pixel shader top: one pixel in per cycle, one result out per cycle, while no
// stall holds the flow. A pixel passes the front end registers, the queue, the divider stages
// and the distance, lookup and add registers; throughput one transfer per cycle when the output
// is not stalled, set by the fully pipelined restoring divider. i_rst_n (synchronous, active low) empties
// the pipeline and queue and loads register defaults: coordinates 0, brightness 0, thickness 1.
module glow_line_pixel_shader #(
    parameter int COORD_BITS = 12
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    // pixel stream in
    input  logic                                       i_s_tvalid,
    output logic                                       o_s_tready,
    // tdata, low bit up: pixel_x, pixel_y, old_level, zero fill to bytes
    input  logic [((2*COORD_BITS+13)/8)*8-1:0]         i_s_tdata,
    // result stream out
    output logic                                       o_m_tvalid,
    input  logic                                       i_m_tready,
    output logic [7:0]                                 o_m_tdata,   // new_level
    output logic                                       o_m_tuser,   // write_enable
    // register write channel
    input  logic                                       i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  logic [glp_pkg::CFG_IDX_BITS-1:0]           i_cfg_index,
    input  logic [COORD_BITS-1:0]                      i_cfg_data
);
    localparam int PB = COORD_BITS - 1;
    localparam int IB = glp_pkg::item_bits(COORD_BITS);

    // configuration registers
    logic signed [COORD_BITS-1:0] r_start_x, r_start_y, r_end_x, r_end_y;
    logic [7:0]                   r_bright;
    logic [5:0]                   r_thick;

    logic          w_q_push, w_q_full, w_q_valid, w_q_pop;
    logic [IB-1:0] w_q_in, w_q_out;

    // writes are always accepted
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_x <= '0;
            r_start_y <= '0;
            r_end_x   <= '0;
            r_end_y   <= '0;
            r_bright  <= 8'd0;
            r_thick   <= 6'd1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                glp_pkg::REG_START_X: r_start_x <= i_cfg_data;
                glp_pkg::REG_START_Y: r_start_y <= i_cfg_data;
                glp_pkg::REG_END_X:   r_end_x   <= i_cfg_data;
                glp_pkg::REG_END_Y:   r_end_y   <= i_cfg_data;
                glp_pkg::REG_BRIGHT:  r_bright  <= i_cfg_data[7:0];
                glp_pkg::REG_THICK:   r_thick   <= i_cfg_data[5:0];
                default: ;            // unused indexes: transfer is dropped
            endcase
        end
    end

    // front end: segment vector, dot products and t classification
    glp_front #(.COORD_BITS(COORD_BITS)) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_s_tvalid),
        .o_ready           (o_s_tready),
        .i_pixel_x         (i_s_tdata[PB-1:0]),
        .i_pixel_y         (i_s_tdata[2*PB-1:PB]),
        .i_old_level       (i_s_tdata[2*PB+7:2*PB]),
        .i_start_x         (r_start_x),
        .i_start_y         (r_start_y),
        .i_end_x           (r_end_x),
        .i_end_y           (r_end_y),
        .i_beam_brightness (r_bright),
        .o_push            (w_q_push),
        .i_full            (w_q_full),
        .o_item            (w_q_in)
    );

    // decoupling queue; front stalls only when it is full
    glp_queue #(.WIDTH(IB)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_q_in),
        .o_full  (w_q_full),
        .o_valid (w_q_valid),
        .i_pop   (w_q_pop),
        .o_data  (w_q_out)
    );

    // back end: divide, distance, glow lookup, saturating add, result register
    glp_back #(.COORD_BITS(COORD_BITS)) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (w_q_valid),
        .o_pop             (w_q_pop),
        .i_item            (w_q_out),
        .i_beam_brightness (r_bright),
        .i_beam_thickness  (r_thick),
        .o_valid           (o_m_tvalid),
        .i_ready           (i_m_tready),
        .o_new_level       (o_m_tdata),
        .o_write_enable    (o_m_tuser)
    );

`ifndef SYNTH
    // a no-write result always carries a zero level
    a_nowrite_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tuser) |-> (o_m_tdata == 8'd0))
        else $error("no-write result with nonzero level");

    // the front end only holds off input when the queue is full
    a_front_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> w_q_full)
        else $error("input stalled with room in the queue");

    // a push into an empty queue is visible the next cycle
    a_queue_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_q_push && !w_q_full) |=> w_q_valid)
        else $error("queue lost a pushed entry");
`endif

endmodule

### sv/glp_front.sv
// Front end: takes pixels, forms the segment vector and dot products, classifies t.
// Depends on glp_pkg; feeds glp_queue.
module glp_front #(
    parameter int COORD_BITS = 12
) (
    input  logic                                           i_clk,
    input  logic                                           i_rst_n,
    input  logic                                           i_valid,
    output logic                                           o_ready,
    input  logic [COORD_BITS-2:0]                          i_pixel_x,
    input  logic [COORD_BITS-2:0]                          i_pixel_y,
    input  logic [7:0]                                     i_old_level,
    input  logic signed [COORD_BITS-1:0]                   i_start_x,
    input  logic signed [COORD_BITS-1:0]                   i_start_y,
    input  logic signed [COORD_BITS-1:0]                   i_end_x,
    input  logic signed [COORD_BITS-1:0]                   i_end_y,
    input  logic [7:0]                                     i_beam_brightness,
    output logic                                           o_push,
    input  logic                                           i_full,
    output logic [glp_pkg::item_bits(COORD_BITS)-1:0]      o_item
);
    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;
    localparam int SW = 2 * COORD_BITS + 3;

    typedef struct packed {
        logic signed [DW-1:0] ddx;
        logic signed [DW-1:0] ddy;
        logic signed [DW-1:0] dx;
        logic signed [DW-1:0] dy;
        logic [SW-1:0]        dot;
        logic [SW-1:0]        len2;
        glp_pkg::t_kind       kind;
        logic [7:0]           old;
    } t_item;

    logic                 w_en;
    logic                 r1_v, r2_v, r3_v;
    logic signed [DW-1:0] r1_ddx, r1_ddy, r1_dx, r1_dy;
    logic [7:0]           r1_old, r2_old;
    logic                 r1_off, r2_off;
    logic signed [DW-1:0] r2_ddx, r2_ddy, r2_dx, r2_dy;
    logic signed [PW-1:0] r2_pxx, r2_pyy, r2_pdx, r2_pdy;
    logic signed [SW-1:0] w_len2, w_dot;
    glp_pkg::t_kind       w_kind;
    t_item                r3_item;

    assign w_en    = !r3_v || !i_full;
    assign o_ready = w_en;
    assign o_push  = r3_v;
    assign o_item  = r3_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else if (w_en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
    end

    // stage 1: differences
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_ddx <= $signed({2'b00, i_pixel_x}) - $signed({i_start_x[COORD_BITS-1], i_start_x});
            r1_ddy <= $signed({2'b00, i_pixel_y}) - $signed({i_start_y[COORD_BITS-1], i_start_y});
            r1_dx  <= $signed({i_end_x[COORD_BITS-1], i_end_x})
                      - $signed({i_start_x[COORD_BITS-1], i_start_x});
            r1_dy  <= $signed({i_end_y[COORD_BITS-1], i_end_y})
                      - $signed({i_start_y[COORD_BITS-1], i_start_y});
            r1_old <= i_old_level;
            r1_off <= (i_beam_brightness == 8'd0);
        end
    end

    // stage 2: products
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_pxx <= r1_dx * r1_dx;
            r2_pyy <= r1_dy * r1_dy;
            r2_pdx <= r1_ddx * r1_dx;
            r2_pdy <= r1_ddy * r1_dy;
            r2_ddx <= r1_ddx;
            r2_ddy <= r1_ddy;
            r2_dx  <= r1_dx;
            r2_dy  <= r1_dy;
            r2_old <= r1_old;
            r2_off <= r1_off;
        end
    end

    // stage 3: sums and classification
    always_comb begin
        w_len2 = {{(SW-PW){r2_pxx[PW-1]}}, r2_pxx} + {{(SW-PW){r2_pyy[PW-1]}}, r2_pyy};
        w_dot  = {{(SW-PW){r2_pdx[PW-1]}}, r2_pdx} + {{(SW-PW){r2_pdy[PW-1]}}, r2_pdy};
        if (r2_off) begin
            w_kind = glp_pkg::K_NONE;
        end else if (w_dot <= 0) begin
            w_kind = glp_pkg::K_ZERO;   // also covers a dot-length segment
        end else if (w_dot >= w_len2) begin
            w_kind = glp_pkg::K_FULL;
        end else begin
            w_kind = glp_pkg::K_DIV;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_item.ddx  <= r2_ddx;
            r3_item.ddy  <= r2_ddy;
            r3_item.dx   <= r2_dx;
            r3_item.dy   <= r2_dy;
            r3_item.dot  <= w_dot;
            r3_item.len2 <= w_len2;
            r3_item.kind <= w_kind;
            r3_item.old  <= r2_old;
        end
    end

endmodule

### sv/glp_queue.sv
// Short FIFO between the front and back ends of the glow line shader.
// Depends on glp_pkg for its depth.
module glp_queue #(
    parameter int WIDTH = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    output logic             o_valid,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data
);
    localparam int DEPTH = glp_pkg::QUEUE_DEPTH;
    localparam int AW    = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [AW-1:0]    r_wr, r_rd;
    logic [AW:0]      r_cnt;
    logic             w_push, w_pop;

    assign o_full  = (r_cnt == (AW + 1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (AW + 1)'(w_push) - (AW + 1)'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

### sv/glp_back.sv
// Back end: pipelined t divide, distance squared, glow lookup and saturating add.
// Depends on glp_pkg; drained from glp_queue, drives the result register.
module glp_back #(
    parameter int COORD_BITS = 12
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_valid,
    output logic                                      o_pop,
    input  logic [glp_pkg::item_bits(COORD_BITS)-1:0] i_item,
    input  logic [7:0]                                i_beam_brightness,
    input  logic [5:0]                                i_beam_thickness,
    output logic                                      o_valid,
    input  logic                                      i_ready,
    output logic [7:0]                                o_new_level,
    output logic                                      o_write_enable
);
    localparam int DW = COORD_BITS + 1;
    localparam int SW = 2 * COORD_BITS + 3;
    localparam int QB = glp_pkg::T_FRAC_BITS;
    localparam int TW = DW + 10;
    localparam int EW = TW + 1;
    localparam int QW = 2 * EW;

    typedef struct packed {
        logic signed [DW-1:0] ddx;
        logic signed [DW-1:0] ddy;
        logic signed [DW-1:0] dx;
        logic signed [DW-1:0] dy;
        logic [SW-1:0]        dot;
        logic [SW-1:0]        len2;
        glp_pkg::t_kind       kind;
        logic [7:0]           old;
    } t_item;

    typedef struct packed {
        logic signed [DW-1:0] ddx;
        logic signed [DW-1:0] ddy;
        logic signed [DW-1:0] dx;
        logic signed [DW-1:0] dy;
        logic [SW-1:0]        rem;
        logic [SW-1:0]        len2;
        logic [QB-1:0]        q;
        glp_pkg::t_kind       kind;
        logic [7:0]           old;
    } t_div;

    // one restoring step: one quotient bit
    function automatic t_div div_step(input t_div d);
        t_div          o;
        logic [SW-1:0] sh;
        o  = d;
        sh = {d.rem[SW-2:0], 1'b0};
        if (sh >= d.len2) begin
            o.rem = sh - d.len2;
            o.q   = {d.q[QB-2:0], 1'b1};
        end else begin
            o.rem = sh;
            o.q   = {d.q[QB-2:0], 1'b0};
        end
        return o;
    endfunction

    logic                 w_en;
    t_item                w_in;
    t_div                 w_d0;
    t_div                 r_div [0:QB-1];
    logic [QB-1:0]        r_div_v;

    logic                 r_m_v, r_e_v, r_s_v, r_d_v, r_t_v, r_out_v;
    logic [8:0]           w_t;
    logic signed [TW-1:0] r_m_tdx, r_m_tdy;
    logic signed [DW-1:0] r_m_ddx, r_m_ddy;
    glp_pkg::t_kind       r_m_kind, r_e_kind, r_s_kind, r_d_kind, r_t_kind;
    logic [7:0]           r_m_old, r_e_old, r_s_old, r_d_old, r_t_old;
    logic signed [EW-1:0] r_e_ex, r_e_ey;
    logic signed [QW-1:0] r_s_xx, r_s_yy;
    logic [QW-1:0]        w_d2, w_r2, w_excess, w_hi;
    logic [5:0]           w_radius;
    logic [11:0]          w_rr;
    logic                 r_d_inside, r_d_ok, r_t_inside, r_t_ok;
    logic [7:0]           r_d_idx;
    logic [15:0]          r_t_prod;
    logic [7:0]           w_contrib;
    logic [8:0]           w_sum;
    logic                 w_we;
    logic [7:0]           r_out_level;
    logic                 r_out_we;

    assign w_en    = !r_out_v || i_ready;
    assign o_pop   = w_en;
    assign w_in    = i_item;
    assign o_valid = r_out_v;
    assign o_new_level    = r_out_level;
    assign o_write_enable = r_out_we;

    always_comb begin
        w_d0.ddx  = w_in.ddx;
        w_d0.ddy  = w_in.ddy;
        w_d0.dx   = w_in.dx;
        w_d0.dy   = w_in.dy;
        w_d0.rem  = w_in.dot;
        w_d0.len2 = w_in.len2;
        w_d0.q    = '0;
        w_d0.kind = w_in.kind;
        w_d0.old  = w_in.old;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_v <= '0;
            r_m_v   <= 1'b0;
            r_e_v   <= 1'b0;
            r_s_v   <= 1'b0;
            r_d_v   <= 1'b0;
            r_t_v   <= 1'b0;
            r_out_v <= 1'b0;
        end else if (w_en) begin
            r_div_v <= {r_div_v[QB-2:0], i_valid};
            r_m_v   <= r_div_v[QB-1];
            r_e_v   <= r_m_v;
            r_s_v   <= r_e_v;
            r_d_v   <= r_s_v;
            r_t_v   <= r_d_v;
            r_out_v <= r_t_v;
        end
    end

    // divider stages
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_div[0] <= div_step(w_d0);
            for (int k = 1; k < QB; k++) begin
                r_div[k] <= div_step(r_div[k-1]);
            end
        end
    end

    // t select and t * d
    always_comb begin
        case (r_div[QB-1].kind)
            glp_pkg::K_FULL: w_t = glp_pkg::T_ONE;
            glp_pkg::K_DIV:  w_t = {1'b0, r_div[QB-1].q};
            default:         w_t = 9'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m_tdx  <= $signed({1'b0, w_t}) * r_div[QB-1].dx;
            r_m_tdy  <= $signed({1'b0, w_t}) * r_div[QB-1].dy;
            r_m_ddx  <= r_div[QB-1].ddx;
            r_m_ddy  <= r_div[QB-1].ddy;
            r_m_kind <= r_div[QB-1].kind;
            r_m_old  <= r_div[QB-1].old;
        end
    end

    // error vector in Q8
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e_ex   <= ({{(EW-DW){r_m_ddx[DW-1]}}, r_m_ddx} << 8)
                        - {{(EW-TW){r_m_tdx[TW-1]}}, r_m_tdx};
            r_e_ey   <= ({{(EW-DW){r_m_ddy[DW-1]}}, r_m_ddy} << 8)
                        - {{(EW-TW){r_m_tdy[TW-1]}}, r_m_tdy};
            r_e_kind <= r_m_kind;
            r_e_old  <= r_m_old;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_s_xx   <= r_e_ex * r_e_ex;
            r_s_yy   <= r_e_ey * r_e_ey;
            r_s_kind <= r_e_kind;
            r_s_old  <= r_e_old;
        end
    end

    // distance squared against radius squared, table index
    always_comb begin
        w_d2     = $unsigned(r_s_xx) + $unsigned(r_s_yy);
        w_radius = 6'(({1'b0, i_beam_thickness} + 7'd1) >> 1);
        w_rr     = w_radius * w_radius;
        w_r2     = QW'({w_rr, 16'd0});
        w_excess = w_d2 - w_r2;
        w_hi     = w_excess >> glp_pkg::GLOW_SHIFT;
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d_inside <= (w_d2 <= w_r2);
            r_d_ok     <= (w_hi < QW'(glp_pkg::GLOW_LEN));
            r_d_idx    <= w_hi[7:0];
            r_d_kind   <= r_s_kind;
            r_d_old    <= r_s_old;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_t_prod   <= i_beam_brightness * glp_pkg::glow_entry(r_d_idx);
            r_t_inside <= r_d_inside;
            r_t_ok     <= r_d_ok;
            r_t_kind   <= r_d_kind;
            r_t_old    <= r_d_old;
        end
    end

    // contribution and saturating add
    always_comb begin
        w_contrib = r_t_inside ? i_beam_brightness : r_t_prod[15:8];
        w_we      = (r_t_kind != glp_pkg::K_NONE) && (r_t_inside || r_t_ok)
                    && (w_contrib != 8'd0);
        w_sum     = {1'b0, r_t_old} + {1'b0, w_contrib};
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_we <= w_we;
            if (!w_we) begin
                r_out_level <= 8'd0;
            end else if (w_sum[8]) begin
                r_out_level <= glp_pkg::LEVEL_MAX;
            end else begin
                r_out_level <= w_sum[7:0];
            end
        end
    end

endmodule
